// File: sv/cmmb_pkg.sv
// Shared types and constants for the cartridge memory map banker.
// No dependencies; imported by the top level, its RAMs' users and the checker.
package cmmb_pkg;

    // Store geometry
    localparam int ROM_BANKS          = 4;
    localparam int BANK_BYTES         = 32768;
    localparam int INTERNAL_RAM_BYTES = 128;
    localparam int MAIN_BYTES         = 65536;
    localparam int ROM_BYTES          = ROM_BANKS * BANK_BYTES;
    localparam int ROM_AW             = $clog2(ROM_BYTES);
    localparam int OFFSET_W           = $clog2(BANK_BYTES);
    localparam int IRAM_AW            = $clog2(INTERNAL_RAM_BYTES);
    localparam int MAIN_AW            = $clog2(MAIN_BYTES);

    // Port widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    // Bus map
    localparam logic [15:0] BIOS_HI    = 16'h0FFF;
    localparam logic [15:0] WRAM_LO    = 16'h2000;
    localparam logic [15:0] WRAM_HI    = 16'h3403;
    localparam logic [15:0] SOUND_ADDR = 16'h3600;
    localparam logic [15:0] CART_LO    = 16'h6000;
    localparam logic [15:0] CART_HI    = 16'h7FFF;
    localparam logic [15:0] ROM_LO     = 16'h8000;
    localparam logic [15:0] ROM_STD_HI = 16'hDFFF;
    localparam logic [15:0] ROM_ALT_HI = 16'hEFFF;
    localparam logic [15:0] HIGH_LO    = 16'hE000;
    localparam logic [15:0] ALT_RAM_LO = 16'hF000;
    localparam logic [15:0] IRAM_LO    = 16'hFF80;
    localparam logic [7:0]  OPEN_BUS   = 8'hFF;

    localparam int PCM_BIT      = 3;
    localparam int WINDOW_LSB   = 5;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_PORTC = 2'd2,
        REQ_LOAD  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_MAPPER_MODE = 2'd0,
        CFG_LOW_RAM     = 2'd1,
        CFG_HIGH_RAM    = 2'd2,
        CFG_BANK_TYPE   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BANK_NONE = 2'd0,
        BANK_TWO  = 2'd1,
        BANK_FOUR = 2'd2,
        BANK_RSVD = 2'd3
    } bank_type_t;

    typedef enum logic [1:0] {
        SRC_OPEN = 2'd0,
        SRC_MAIN = 2'd1,
        SRC_ROM  = 2'd2,
        SRC_IRAM = 2'd3
    } src_t;

    // What the read stage needs to build the result item
    typedef struct packed {
        src_t src;
        logic sound;
        logic pcm_strobe;
        logic pcm_level;
    } rd_info_t;

    // Bank number modulo ROM_BANKS (value is at most 3)
    function automatic logic [1:0] bank_wrap(input logic [1:0] bank);
        logic [2:0] v;
        v = {1'b0, bank};
        if (v >= 3'(ROM_BANKS)) v = v - 3'(ROM_BANKS);
        if (v >= 3'(ROM_BANKS)) v = v - 3'(ROM_BANKS);
        if (v >= 3'(ROM_BANKS)) v = v - 3'(ROM_BANKS);
        return v[1:0];
    endfunction

    function automatic logic [ROM_AW-1:0] rom_addr(input logic [1:0] bank,
                                                  input logic [15:0] addr);
        logic [OFFSET_W+1:0] base;
        base = {bank_wrap(bank), {OFFSET_W{1'b0}}};
        return ROM_AW'(base) + ROM_AW'(addr[OFFSET_W-1:0]);
    endfunction

endpackage

// File: sv/cmmb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cmmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cartridge_memory_map_banker.sv
// Cartridge memory map banker: bus decode, bank window, main/ROM/internal RAMs.
// Depends on cmmb_pkg and cmmb_ram.
// Path from input accept to m_tvalid: RAM read register, then output register.
// Throughput: one item per cycle while m_tready does not stall the output; each RAM has a single registered read.
// Reset (aresetn low, synchronous): clears config registers, bank window and valids;
// RAM contents are not cleared and read as garbage until written.
module cartridge_memory_map_banker
    import cmmb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // addr[15:0], data[23:16], load_bank[25:24]
    input  logic [S_TUSER_W-1:0] s_tuser,  // req_type[1:0], load_to_rom[2]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_data[7:0], sound_strobe[8],
                                           // pcm_strobe[9], pcm_level[10]
);

    // config and window
    logic       mapper_mode_reg;
    logic       low_ram_en_reg;
    logic       high_ram_en_reg;
    logic [1:0] bank_type_reg;
    logic [1:0] bank_window_reg, bank_window_next;

    // read stage and output register
    logic                 rd_valid_reg;
    rd_info_t             rd_info_reg, rd_info_next;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // request fields
    req_t        req;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        load_to_rom;
    logic [1:0]  load_bank;

    logic in_accept, out_load;

    // RAM ports
    logic                main_we, main_re;
    logic                rom_we, rom_re;
    logic                iram_we, iram_re;
    logic [ROM_AW-1:0]   rom_waddr, rom_raddr;
    logic [7:0]          main_rdata, rom_rdata, iram_rdata;

    assign req         = req_t'(s_tuser[1:0]);
    assign load_to_rom = s_tuser[2];
    assign addr        = s_tdata[15:0];
    assign data        = s_tdata[23:16];
    assign load_bank   = s_tdata[25:24];

    assign out_load  = rd_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !rd_valid_reg || out_load;
    assign in_accept = s_tvalid && s_tready;

    assign rom_raddr = rom_addr(bank_window_reg, addr);
    assign rom_waddr = rom_addr(load_bank, addr);

    // request decode
    always_comb begin
        logic in_bios, in_wram, in_iram;
        in_bios = (addr <= BIOS_HI);
        in_wram = (addr >= WRAM_LO) && (addr <= WRAM_HI);
        in_iram = (addr >= IRAM_LO);

        main_we = 1'b0;
        main_re = 1'b0;
        rom_we  = 1'b0;
        rom_re  = 1'b0;
        iram_we = 1'b0;
        iram_re = 1'b0;
        bank_window_next = bank_window_reg;
        rd_info_next = '{src: SRC_OPEN, sound: 1'b0, pcm_strobe: 1'b0, pcm_level: 1'b0};

        case (req)
            REQ_READ: begin
                if (in_bios || in_wram) begin
                    rd_info_next.src = SRC_MAIN;
                end else if (in_iram) begin
                    rd_info_next.src = SRC_IRAM;
                end else if (mapper_mode_reg) begin
                    if (addr >= ROM_LO && addr <= ROM_ALT_HI) begin
                        rd_info_next.src = SRC_ROM;
                    end else if (addr >= ALT_RAM_LO) begin
                        rd_info_next.src = SRC_MAIN;
                    end
                end else begin
                    if (addr >= CART_LO && addr <= CART_HI) begin
                        if (low_ram_en_reg) rd_info_next.src = SRC_MAIN;
                    end else if (addr >= ROM_LO && addr <= ROM_STD_HI) begin
                        rd_info_next.src = SRC_ROM;
                    end else if (addr >= HIGH_LO) begin
                        rd_info_next.src = high_ram_en_reg ? SRC_MAIN : SRC_ROM;
                    end
                end
                main_re = (rd_info_next.src == SRC_MAIN);
                rom_re  = (rd_info_next.src == SRC_ROM);
                iram_re = (rd_info_next.src == SRC_IRAM);
            end
            REQ_WRITE: begin
                if (addr == SOUND_ADDR) begin
                    rd_info_next.sound = 1'b1;
                end else if (in_wram) begin
                    main_we = 1'b1;
                end else if (in_iram) begin
                    iram_we = 1'b1;
                end else if (mapper_mode_reg) begin
                    main_we = (addr >= ALT_RAM_LO);
                end else if (addr >= CART_LO && addr <= CART_HI) begin
                    main_we = low_ram_en_reg;
                end else begin
                    main_we = (addr >= HIGH_LO) && high_ram_en_reg;
                end
            end
            REQ_PORTC: begin
                rd_info_next.pcm_strobe = 1'b1;
                rd_info_next.pcm_level  = data[PCM_BIT];
                case (bank_type_t'(bank_type_reg))
                    BANK_TWO:  bank_window_next = {1'b0, data[WINDOW_LSB]};
                    BANK_FOUR: bank_window_next = data[WINDOW_LSB+1:WINDOW_LSB];
                    default:   bank_window_next = bank_window_reg;
                endcase
            end
            default: begin
                // image load goes straight into the target store
                rom_we  = load_to_rom;
                main_we = !load_to_rom;
            end
        endcase
    end

    cmmb_ram #(.WIDTH(8), .DEPTH(MAIN_BYTES)) u_main_ram (
        .aclk  (aclk),
        .we    (in_accept && main_we),
        .waddr (addr[MAIN_AW-1:0]),
        .wdata (data),
        .re    (in_accept && main_re),
        .raddr (addr[MAIN_AW-1:0]),
        .rdata (main_rdata)
    );

    cmmb_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom_ram (
        .aclk  (aclk),
        .we    (in_accept && rom_we),
        .waddr (rom_waddr),
        .wdata (data),
        .re    (in_accept && rom_re),
        .raddr (rom_raddr),
        .rdata (rom_rdata)
    );

    cmmb_ram #(.WIDTH(8), .DEPTH(INTERNAL_RAM_BYTES)) u_iram (
        .aclk  (aclk),
        .we    (in_accept && iram_we),
        .waddr (addr[IRAM_AW-1:0]),
        .wdata (data),
        .re    (in_accept && iram_re),
        .raddr (addr[IRAM_AW-1:0]),
        .rdata (iram_rdata)
    );

    // result assembly from the RAM read registers
    always_comb begin
        logic [7:0] rd;
        case (rd_info_reg.src)
            SRC_MAIN: rd = main_rdata;
            SRC_ROM:  rd = rom_rdata;
            SRC_IRAM: rd = iram_rdata;
            default:  rd = OPEN_BUS;
        endcase
        m_tdata_next = {5'b0, rd_info_reg.pcm_level, rd_info_reg.pcm_strobe,
                        rd_info_reg.sound, rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_mode_reg <= 1'b0;
            low_ram_en_reg  <= 1'b0;
            high_ram_en_reg <= 1'b0;
            bank_type_reg   <= 2'd0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_MAPPER_MODE: mapper_mode_reg <= cfg_wdata[0];
                CFG_LOW_RAM:     low_ram_en_reg  <= cfg_wdata[0];
                CFG_HIGH_RAM:    high_ram_en_reg <= cfg_wdata[0];
                CFG_BANK_TYPE:   bank_type_reg   <= cfg_wdata;
                default:         mapper_mode_reg <= mapper_mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_window_reg <= 2'd0;
            rd_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (in_accept) begin
                bank_window_reg <= bank_window_next;
            end
            if (in_accept) begin
                rd_valid_reg <= 1'b1;
            end else if (out_load) begin
                rd_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_info_reg <= rd_info_next;
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: sv/cmmb_checker.sv
// Port-level checks for the cartridge memory map banker, bound to the top level.
// Depends on cmmb_pkg.
module cmmb_checker
    import cmmb_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // no result item right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an item accepted while the sink is ready shows up after the RAM read register and the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && m_tready |=> ##1 m_tvalid)
        else $error("result item missing after accept");

    // port C and sound results never carry read data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[8] || m_tdata[9]) |-> m_tdata[7:0] == OPEN_BUS)
        else $error("strobe result with read data");

    // strobes are exclusive, and a level only comes with a port C strobe
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]) && (m_tdata[9] || !m_tdata[10]))
        else $error("inconsistent strobe flags");

endmodule

bind cartridge_memory_map_banker cmmb_checker u_cmmb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
